@@ rtl/pffc_pkg.sv @@
// Shared types and constants for the panel flow force coefficient block.
// Used by every module under rtl except pffc_sqrt; no dependencies of its own.
`timescale 1ns / 1ps
package pffc_pkg;

  localparam int FRAC_BITS   = 15;
  localparam int AREA_W      = 40;
  localparam int COEFF_SHIFT = 27 - FRAC_BITS;
  localparam int CFG_IDX_W   = 2;

  localparam logic [15:0] FRAC_ONE = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] CFG_MODEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_Z = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DOT, OP_COS, OP_AL, OP_PROJ, OP_AV, OP_AC, OP_SQ,
    OP_CPS, OP_T1, OP_CT, OP_CPN, OP_AXA, OP_AXB, OP_AXF, OP_AXG,
    OP_DIVGO, OP_EMIT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic model;
    logic last;
    logic area_nz;
    logic sqrt_done;
    logic div_done;
  } status_t;

  function automatic logic [15:0] frac_sat(input logic [15:0] v);
    return (v > FRAC_ONE) ? FRAC_ONE : v;
  endfunction

endpackage

@@ rtl/pffc_sqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on nothing; used by the datapath for the tangential term.
`timescale 1ns / 1ps
module pffc_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] v_i,
  output logic        done_o,
  output logic [15:0] root_o
);

  logic [31:0] v_q;
  logic [17:0] rem_q;
  logic [15:0] root_q;
  logic [4:0]  cnt_q;
  logic        run_q, done_q;
  logic [19:0] rem_sh, trial;
  logic        ge;

  assign rem_sh = {rem_q, v_q[31:30]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 5'd16;
      end else if (run_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= v_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      v_q    <= {v_q[29:0], 2'b00};
      rem_q  <= ge ? 18'(rem_sh - trial) : rem_sh[17:0];
      root_q <= {root_q[14:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ rtl/pffc_div.sv @@
// Restoring divider for the coefficient step, one quotient bit per cycle.
// Uses pffc_pkg constants for the area width and the output scaling.
`timescale 1ns / 1ps
module pffc_div #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic [ACC_WIDTH-1:0]                      mag_i,
  input  logic [pffc_pkg::AREA_W-1:0]               den_i,
  output logic                                      done_o,
  output logic [ACC_WIDTH+pffc_pkg::COEFF_SHIFT-1:0] quo_o
);

  localparam int NW = ACC_WIDTH + pffc_pkg::COEFF_SHIFT;
  localparam int CW = $clog2(NW + 1);
  localparam int DW = pffc_pkg::AREA_W;

  logic [NW-1:0] n_q;
  logic [DW-1:0] rem_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_q, n_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(NW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend bits shift out the top while quotient bits fill from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= {mag_i, {pffc_pkg::COEFF_SHIFT{1'b0}}};
      rem_q <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
      n_q   <= {n_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = n_q;

endmodule

@@ rtl/pffc_dp.sv @@
// Datapath: configuration registers, one shared multiplier, accumulators, results.
// Depends on pffc_pkg, pffc_sqrt and pffc_div; driven by pffc_ctrl commands.
`timescale 1ns / 1ps
module pffc_dp #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [pffc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i,
  input  logic signed [15:0]             normal_x_i,
  input  logic signed [15:0]             normal_y_i,
  input  logic signed [15:0]             normal_z_i,
  input  logic [15:0]                    panel_area_i,
  input  logic [15:0]                    lit_fraction_i,
  input  logic [15:0]                    normal_accom_i,
  input  logic [15:0]                    tangent_accom_i,
  input  logic [15:0]                    wall_speed_ratio_i,
  input  logic                           last_panel_i,
  input  pffc_pkg::cmd_t                 cmd_i,
  output pffc_pkg::status_t              status_o,
  output logic                           valid_o,
  output logic [15:0]                    panel_cosine_o,
  output logic signed [31:0]             coeff_x_o,
  output logic signed [31:0]             coeff_y_o,
  output logic signed [31:0]             coeff_z_o,
  output logic [31:0]                    reference_area_o,
  output logic                           done_res_o,
  output logic                           zero_area_o
);

  localparam int AW = pffc_pkg::AREA_W;
  localparam int GW = 45;
  localparam int SW = ((ACC_WIDTH > GW) ? ACC_WIDTH : GW) + 1;
  localparam int NW = ACC_WIDTH + pffc_pkg::COEFF_SHIFT;

  localparam logic signed [SW-1:0] ACC_MAX =
    {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;

  // configuration
  logic                     model_q;
  logic signed [15:0]       dir_q [3];

  // captured item
  logic signed [15:0]       n_q [3];
  logic [15:0]              area_q, lit_q, an_q, at_q, vw_q;
  logic                     last_q;

  // working registers
  logic signed [33:0]       p_q, a_q, e_q;
  logic [15:0]              c_q;
  logic                     active_q;
  logic [30:0]              al_q;
  logic [17:0]              inner_q, cp_q;
  logic [16:0]              t1_q, ct_q;
  logic signed [23:0]       f_q;
  logic signed [ACC_WIDTH-1:0] acc_q [3];
  logic [AW-1:0]            area_acc_q;
  logic [31:0]              cq_q [3];
  logic                     neg_q;

  logic                     strobe_q;

  // shared multiplier
  logic signed [35:0]       mul_a;
  logic signed [23:0]       mul_b;
  logic signed [59:0]       prod;

  logic signed [15:0]       n_sel, d_sel;
  logic signed [33:0]       p_sh;
  logic [15:0]              c_next;
  logic [AW:0]              area_sum;
  logic signed [59:0]       f2;
  logic signed [GW-1:0]     g;
  logic signed [SW-1:0]     acc_sum;
  logic signed [ACC_WIDTH-1:0] acc_sat;
  logic signed [ACC_WIDTH-1:0] acc_sel;
  logic [ACC_WIDTH-1:0]     mag;
  logic [31:0]              coeff_sat;

  logic                     sqrt_start, sqrt_done;
  logic [31:0]              sqrt_v;
  logic [15:0]              sqrt_root;
  logic                     div_start, div_done;
  logic [NW-1:0]            div_quo;

  assign n_sel   = n_q[cmd_i.axis];
  assign d_sel   = dir_q[cmd_i.axis];
  assign acc_sel = acc_q[cmd_i.axis];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      pffc_pkg::OP_DOT: begin
        mul_a = {{20{n_sel[15]}}, n_sel};
        mul_b = {{8{d_sel[15]}}, d_sel};
      end
      pffc_pkg::OP_AL: begin
        mul_a = {20'd0, area_q};
        mul_b = {8'd0, lit_q};
      end
      pffc_pkg::OP_PROJ: begin
        mul_a = {5'd0, al_q};
        mul_b = {8'd0, c_q};
      end
      pffc_pkg::OP_AV: begin
        mul_a = {20'd0, an_q};
        mul_b = {8'd0, vw_q};
      end
      pffc_pkg::OP_AC: begin
        mul_a = {19'd0, 17'h10000 - {1'b0, an_q}};
        mul_b = {8'd0, c_q};
      end
      pffc_pkg::OP_SQ, pffc_pkg::OP_CPN: begin
        mul_a = {20'd0, c_q};
        mul_b = {8'd0, c_q};
      end
      pffc_pkg::OP_CPS: begin
        mul_a = {18'd0, inner_q};
        mul_b = {8'd0, c_q};
      end
      pffc_pkg::OP_T1: begin
        mul_a = {20'd0, at_q};
        mul_b = {8'd0, sqrt_root};
      end
      pffc_pkg::OP_CT: begin
        mul_a = {19'd0, t1_q};
        mul_b = {8'd0, c_q};
      end
      pffc_pkg::OP_AXA: begin
        mul_a = {18'd0, cp_q};
        mul_b = {{8{n_sel[15]}}, n_sel};
      end
      pffc_pkg::OP_AXB: begin
        mul_a = {20'd0, c_q};
        mul_b = {{8{n_sel[15]}}, n_sel};
      end
      pffc_pkg::OP_AXF: begin
        mul_a = {{2{e_q[33]}}, e_q};
        mul_b = {7'd0, ct_q};
      end
      pffc_pkg::OP_AXG: begin
        mul_a = {5'd0, al_q};
        mul_b = f_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // clamp the cosine into [0, one]
  assign p_sh = p_q >>> pffc_pkg::FRAC_BITS;
  always_comb begin
    if (p_q > 34'sd0) begin
      c_next = (p_sh > 34'sd32768) ? pffc_pkg::FRAC_ONE : p_sh[15:0];
    end else begin
      c_next = '0;
    end
  end

  assign area_sum = {1'b0, area_acc_q} + {{(AW-16){1'b0}}, prod[46:30]};
  assign f2       = prod - ({{26{a_q[33]}}, a_q} <<< pffc_pkg::FRAC_BITS);
  assign g        = prod[59:15];
  assign acc_sum  = {{(SW-ACC_WIDTH){acc_sel[ACC_WIDTH-1]}}, acc_sel}
                  + {{(SW-GW){g[GW-1]}}, g};

  always_comb begin
    if (acc_sum > ACC_MAX) begin
      acc_sat = ACC_MAX[ACC_WIDTH-1:0];
    end else if (acc_sum < ACC_MIN) begin
      acc_sat = ACC_MIN[ACC_WIDTH-1:0];
    end else begin
      acc_sat = acc_sum[ACC_WIDTH-1:0];
    end
  end

  assign mag = acc_sel[ACC_WIDTH-1] ? ACC_WIDTH'(-acc_sel) : acc_sel;

  always_comb begin
    if (neg_q) begin
      if ((|div_quo[NW-1:32]) || (div_quo[31] && (|div_quo[30:0]))) begin
        coeff_sat = 32'h8000_0000;
      end else begin
        coeff_sat = 32'(-div_quo[31:0]);
      end
    end else begin
      coeff_sat = (|div_quo[NW-1:31]) ? 32'h7FFF_FFFF : div_quo[31:0];
    end
  end

  assign sqrt_start = (cmd_i.op == pffc_pkg::OP_SQ);
  assign sqrt_v     = 32'h4000_0000 - prod[31:0];
  assign div_start  = (cmd_i.op == pffc_pkg::OP_DIVGO);

  pffc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .v_i     (sqrt_v),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  pffc_div #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (mag),
    .den_i   (area_acc_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // configuration and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q    <= 1'b0;
      dir_q[0]   <= 16'sd0;
      dir_q[1]   <= 16'sd0;
      dir_q[2]   <= 16'sh8000;
      acc_q[0]   <= '0;
      acc_q[1]   <= '0;
      acc_q[2]   <= '0;
      area_acc_q <= '0;
      strobe_q   <= 1'b0;
    end else begin
      strobe_q <= (cmd_i.op == pffc_pkg::OP_EMIT);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          pffc_pkg::CFG_MODEL:  model_q  <= cfg_data_i[0];
          pffc_pkg::CFG_FLOW_X: dir_q[0] <= cfg_data_i;
          pffc_pkg::CFG_FLOW_Y: dir_q[1] <= cfg_data_i;
          pffc_pkg::CFG_FLOW_Z: dir_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == pffc_pkg::OP_PROJ && active_q) begin
        area_acc_q <= area_sum[AW] ? {AW{1'b1}} : area_sum[AW-1:0];
      end
      if (cmd_i.op == pffc_pkg::OP_AXG) begin
        acc_q[cmd_i.axis] <= acc_sat;
      end
      // end of evaluation: start the next one from zero
      if (cmd_i.op == pffc_pkg::OP_EMIT && last_q) begin
        acc_q[0]   <= '0;
        acc_q[1]   <= '0;
        acc_q[2]   <= '0;
        area_acc_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      pffc_pkg::OP_LOAD: begin
        n_q[0] <= normal_x_i;
        n_q[1] <= normal_y_i;
        n_q[2] <= normal_z_i;
        area_q <= panel_area_i;
        lit_q  <= pffc_pkg::frac_sat(lit_fraction_i);
        an_q   <= pffc_pkg::frac_sat(normal_accom_i);
        at_q   <= pffc_pkg::frac_sat(tangent_accom_i);
        vw_q   <= pffc_pkg::frac_sat(wall_speed_ratio_i);
        last_q <= last_panel_i;
      end
      pffc_pkg::OP_DOT: begin
        p_q <= ((cmd_i.axis == 2'd0) ? 34'sd0 : p_q) - $signed(prod[33:0]);
      end
      pffc_pkg::OP_COS: begin
        c_q      <= c_next;
        active_q <= (c_next != 16'd0) && (lit_q != 16'd0);
      end
      pffc_pkg::OP_AL:  al_q    <= prod[30:0];
      pffc_pkg::OP_AV:  inner_q <= prod[32:15];
      pffc_pkg::OP_AC:  inner_q <= inner_q + prod[32:15];
      pffc_pkg::OP_CPS: cp_q    <= prod[31:14];
      pffc_pkg::OP_T1:  t1_q    <= prod[30:14];
      pffc_pkg::OP_CT:  ct_q    <= prod[31:15];
      pffc_pkg::OP_CPN: begin
        cp_q <= {1'b0, prod[30:14]};
        ct_q <= '0;
      end
      pffc_pkg::OP_AXA: a_q <= $signed(prod[33:0]);
      pffc_pkg::OP_AXB: begin
        e_q <= $signed(prod[33:0])
             + ({{18{d_sel[15]}}, d_sel} <<< pffc_pkg::FRAC_BITS);
      end
      pffc_pkg::OP_AXF:   f_q   <= f2[53:30];
      pffc_pkg::OP_DIVGO: neg_q <= acc_sel[ACC_WIDTH-1];
      pffc_pkg::OP_EMIT: begin
        panel_cosine_o   <= c_q;
        reference_area_o <= (|area_acc_q[AW-1:32]) ? 32'hFFFF_FFFF : area_acc_q[31:0];
        done_res_o       <= last_q;
        zero_area_o      <= last_q && (area_acc_q == '0);
        if (last_q && (area_acc_q != '0)) begin
          coeff_x_o <= cq_q[0];
          coeff_y_o <= cq_q[1];
          coeff_z_o <= cq_q[2];
        end else begin
          coeff_x_o <= '0;
          coeff_y_o <= '0;
          coeff_z_o <= '0;
        end
      end
      default: ;
    endcase
    if (div_done) begin
      cq_q[cmd_i.axis] <= coeff_sat;
    end
  end

  assign valid_o = strobe_q;

  assign status_o.active    = active_q;
  assign status_o.model     = model_q;
  assign status_o.last      = last_q;
  assign status_o.area_nz   = (area_acc_q != '0);
  assign status_o.sqrt_done = sqrt_done;
  assign status_o.div_done  = div_done;

endmodule

@@ rtl/pffc_ctrl.sv @@
// Controller: sequences the datapath for each panel, one operation per cycle
// when not waiting; depends on pffc_pkg for the command and status structs.
`timescale 1ns / 1ps
module pffc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  pffc_pkg::status_t status_i,
  output pffc_pkg::cmd_t    cmd_o,
  output logic              busy_o
);

  typedef enum logic [20:0] {
    ST_IDLE  = 21'h000001,
    ST_DOT   = 21'h000002,
    ST_COS   = 21'h000004,
    ST_AL    = 21'h000008,
    ST_PROJ  = 21'h000010,
    ST_AV    = 21'h000020,
    ST_AC    = 21'h000040,
    ST_SQ    = 21'h000080,
    ST_SQW   = 21'h000100,
    ST_CPS   = 21'h000200,
    ST_T1    = 21'h000400,
    ST_CT    = 21'h000800,
    ST_CPN   = 21'h001000,
    ST_AXA   = 21'h002000,
    ST_AXB   = 21'h004000,
    ST_AXF   = 21'h008000,
    ST_AXG   = 21'h010000,
    ST_FIN   = 21'h020000,
    ST_DIVGO = 21'h040000,
    ST_DIVW  = 21'h080000,
    ST_EMIT  = 21'h100000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] axis_q, axis_d;

  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    cmd_o.op   = pffc_pkg::OP_NONE;
    cmd_o.axis = axis_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.op = pffc_pkg::OP_LOAD;
          axis_d   = 2'd0;
          state_d  = ST_DOT;
        end
      end
      ST_DOT: begin
        cmd_o.op = pffc_pkg::OP_DOT;
        if (axis_q == 2'd2) begin
          state_d = ST_COS;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      ST_COS: begin
        cmd_o.op = pffc_pkg::OP_COS;
        state_d  = ST_AL;
      end
      ST_AL: begin
        cmd_o.op = pffc_pkg::OP_AL;
        state_d  = ST_PROJ;
      end
      ST_PROJ: begin
        cmd_o.op = pffc_pkg::OP_PROJ;
        axis_d   = 2'd0;
        priority if (!status_i.active) state_d = ST_FIN;
        else if (status_i.model)        state_d = ST_AV;
        else                            state_d = ST_CPN;
      end
      ST_AV: begin
        cmd_o.op = pffc_pkg::OP_AV;
        state_d  = ST_AC;
      end
      ST_AC: begin
        cmd_o.op = pffc_pkg::OP_AC;
        state_d  = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.op = pffc_pkg::OP_SQ;
        state_d  = ST_SQW;
      end
      ST_SQW: begin
        if (status_i.sqrt_done) begin
          state_d = ST_CPS;
        end
      end
      ST_CPS: begin
        cmd_o.op = pffc_pkg::OP_CPS;
        state_d  = ST_T1;
      end
      ST_T1: begin
        cmd_o.op = pffc_pkg::OP_T1;
        state_d  = ST_CT;
      end
      ST_CT: begin
        cmd_o.op = pffc_pkg::OP_CT;
        state_d  = ST_AXA;
      end
      ST_CPN: begin
        cmd_o.op = pffc_pkg::OP_CPN;
        state_d  = ST_AXA;
      end
      ST_AXA: begin
        cmd_o.op = pffc_pkg::OP_AXA;
        state_d  = ST_AXB;
      end
      ST_AXB: begin
        cmd_o.op = pffc_pkg::OP_AXB;
        state_d  = ST_AXF;
      end
      ST_AXF: begin
        cmd_o.op = pffc_pkg::OP_AXF;
        state_d  = ST_AXG;
      end
      ST_AXG: begin
        cmd_o.op = pffc_pkg::OP_AXG;
        if (axis_q == 2'd2) begin
          state_d = ST_FIN;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_AXA;
        end
      end
      ST_FIN: begin
        axis_d = 2'd0;
        if (status_i.last && status_i.area_nz) begin
          state_d = ST_DIVGO;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DIVGO: begin
        cmd_o.op = pffc_pkg::OP_DIVGO;
        state_d  = ST_DIVW;
      end
      ST_DIVW: begin
        // hold the axis until the quotient is stored
        if (status_i.div_done) begin
          if (axis_q == 2'd2) begin
            state_d = ST_EMIT;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = ST_DIVGO;
          end
        end
      end
      ST_EMIT: begin
        cmd_o.op = pffc_pkg::OP_EMIT;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

`ifndef SYNTH
  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q != 2'd3)
    else $error("axis counter out of range");
  a_sqrt_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.sqrt_done |-> state_q == ST_SQW)
    else $error("square root finished outside its wait state");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> state_q == ST_DIVW)
    else $error("division finished outside its wait state");
`endif

endmodule

@@ rtl/panel_flow_force_coefficients.sv @@
// An unlit panel skips the force steps, Storch adds a serial square root over
// Newton, and a last panel with nonzero area adds three serial divisions.
// Throughput: one panel at a time; busy_o stays high until the result strobe.
// Reset clears accumulators, configuration to its defaults and the controller.
// Top level; depends on pffc_pkg, pffc_ctrl and pffc_dp; results cannot stall.
`timescale 1ns / 1ps
module panel_flow_force_coefficients #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pffc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic signed [15:0]             normal_x_i,
  input  logic signed [15:0]             normal_y_i,
  input  logic signed [15:0]             normal_z_i,
  input  logic [15:0]                    panel_area_i,
  input  logic [15:0]                    lit_fraction_i,
  input  logic [15:0]                    normal_accom_i,
  input  logic [15:0]                    tangent_accom_i,
  input  logic [15:0]                    wall_speed_ratio_i,
  input  logic                           last_panel_i,
  output logic                           valid_o,
  output logic [15:0]                    panel_cosine_o,
  output logic signed [31:0]             coeff_x_o,
  output logic signed [31:0]             coeff_y_o,
  output logic signed [31:0]             coeff_z_o,
  output logic [31:0]                    reference_area_o,
  output logic                           done_res_o,
  output logic                           zero_area_o
);

  pffc_pkg::cmd_t    cmd;
  pffc_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  pffc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  pffc_dp #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .normal_x_i         (normal_x_i),
    .normal_y_i         (normal_y_i),
    .normal_z_i         (normal_z_i),
    .panel_area_i       (panel_area_i),
    .lit_fraction_i     (lit_fraction_i),
    .normal_accom_i     (normal_accom_i),
    .tangent_accom_i    (tangent_accom_i),
    .wall_speed_ratio_i (wall_speed_ratio_i),
    .last_panel_i       (last_panel_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .valid_o            (valid_o),
    .panel_cosine_o     (panel_cosine_o),
    .coeff_x_o          (coeff_x_o),
    .coeff_y_o          (coeff_y_o),
    .coeff_z_o          (coeff_z_o),
    .reference_area_o   (reference_area_o),
    .done_res_o         (done_res_o),
    .zero_area_o        (zero_area_o)
  );

`ifndef SYNTH
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result strobe while a transaction is in flight");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !valid_o)
    else $error("accepted transaction did not raise busy");
  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");
  a_zero_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_area_o |-> done_res_o && coeff_x_o == 32'sd0)
    else $error("zero area flagged on a non-final result");
`endif

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for panel_flow_force_coefficients: a directed panel
// table, then random panel sets under several flow/model settings.
// Depends on rtl/pffc_pkg.sv and the RTL of the block.
`timescale 1ns / 1ps
module tb;

  localparam longint ACC_MAX  = (64'sd1 <<< 47) - 1;
  localparam longint ACC_MIN  = -(64'sd1 <<< 47);
  localparam longint AREA_MAX = (64'sd1 <<< 40) - 1;
  localparam int     LIMIT    = 2000000;

  typedef struct {
    logic [15:0] nx, ny, nz, area, lit, an, at, vw;
    logic        last;
  } panel_t;

  typedef struct {
    logic [15:0] cosine;
    logic [31:0] cx, cy, cz, refa;
    logic        done, zarea;
  } coeff_res_t;

  typedef struct {
    panel_t     p;
    logic       known;
    coeff_res_t r;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pffc_pkg::CFG_IDX_W-1:0] cfg_index_i = pffc_pkg::CFG_MODEL;
  logic [15:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [15:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic [15:0] panel_area_i = '0, lit_fraction_i = '0, normal_accom_i = '0;
  logic [15:0] tangent_accom_i = '0, wall_speed_ratio_i = '0;
  logic last_panel_i = 1'b0;
  logic valid_o;
  logic [15:0] panel_cosine_o;
  logic signed [31:0] coeff_x_o, coeff_y_o, coeff_z_o;
  logic [31:0] reference_area_o;
  logic done_res_o, zero_area_o;

  panel_flow_force_coefficients i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic   storch_mode;
  longint flow_x, flow_y, flow_z;
  longint force_x, force_y, force_z, area_sum;

  coeff_res_t pending_q[$];
  bit failed = 0;
  int cycles = 0;

  function automatic longint sat_frac(logic [15:0] v);
    return (v > 16'h8000) ? 64'sd32768 : longint'(v);
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 60;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint sat_acc(longint a, longint b);
    longint s;
    s = a + b;
    if (s > ACC_MAX) return ACC_MAX;
    if (s < ACC_MIN) return ACC_MIN;
    return s;
  endfunction

  function automatic longint axis_push(longint n, longint d, longint c, longint cp,
                                       longint ct, longint al);
    longint f;
    f = (-cp * n * 32768 + ct * (c * n + d * 32768)) >>> 30;
    return (f * al) >>> 15;
  endfunction

  function automatic logic [31:0] to_coeff(longint f, longint a);
    longint mag, q;
    mag = (f < 0) ? -f : f;
    q = (mag <<< 12) / a;
    if (f < 0) begin
      if (q > 64'sd2147483648) q = 64'sd2147483648;
      return 32'(-q);
    end
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    return 32'(q);
  endfunction

  function automatic coeff_res_t predict_panel(panel_t p);
    coeff_res_t r;
    longint nx, ny, nz, lit, an, at, vw, dot, c, al, cp, ct, inner, s;
    nx = longint'($signed(p.nx));
    ny = longint'($signed(p.ny));
    nz = longint'($signed(p.nz));
    lit = sat_frac(p.lit);
    an = sat_frac(p.an);
    at = sat_frac(p.at);
    vw = sat_frac(p.vw);
    dot = -(nx * flow_x + ny * flow_y + nz * flow_z);
    c = 0;
    if (dot > 0) begin
      c = dot >>> 15;
      if (c > 32768) c = 32768;
    end
    if (c != 0 && lit != 0) begin
      al = longint'(p.area) * lit;
      area_sum = area_sum + ((al * c) >>> 30);
      if (area_sum > AREA_MAX) area_sum = AREA_MAX;
      ct = 0;
      if (storch_mode) begin
        inner = ((an * vw) >>> 15) + (((65536 - an) * c) >>> 15);
        s = int_sqrt(64'sd1073741824 - c * c);
        cp = (2 * c * inner) >>> 15;
        ct = ((((2 * at * s) >>> 15) * c) >>> 15);
      end else begin
        cp = (2 * c * c) >>> 15;
      end
      force_x = sat_acc(force_x, axis_push(nx, flow_x, c, cp, ct, al));
      force_y = sat_acc(force_y, axis_push(ny, flow_y, c, cp, ct, al));
      force_z = sat_acc(force_z, axis_push(nz, flow_z, c, cp, ct, al));
    end
    r.cosine = c[15:0];
    r.cx = '0;
    r.cy = '0;
    r.cz = '0;
    r.refa = (area_sum > 64'sd4294967295) ? 32'hFFFF_FFFF : area_sum[31:0];
    r.done = p.last;
    r.zarea = 1'b0;
    if (p.last) begin
      if (area_sum == 0) begin
        r.zarea = 1'b1;
      end else begin
        r.cx = to_coeff(force_x, area_sum);
        r.cy = to_coeff(force_y, area_sum);
        r.cz = to_coeff(force_z, area_sum);
      end
      force_x = 0;
      force_y = 0;
      force_z = 0;
      area_sum = 0;
    end
    return r;
  endfunction

  task automatic write_reg(logic [pffc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    case (idx)
      pffc_pkg::CFG_MODEL:  storch_mode = data[0];
      pffc_pkg::CFG_FLOW_X: flow_x = longint'($signed(data));
      pffc_pkg::CFG_FLOW_Y: flow_y = longint'($signed(data));
      pffc_pkg::CFG_FLOW_Z: flow_z = longint'($signed(data));
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Hold start until the transaction is taken, then queue its expectation.
  task automatic send_panel(panel_t p, logic known, coeff_res_t typed);
    coeff_res_t r;
    int gap;
    @(negedge clk_i);
    start_i = 1'b1;
    normal_x_i = p.nx;
    normal_y_i = p.ny;
    normal_z_i = p.nz;
    panel_area_i = p.area;
    lit_fraction_i = p.lit;
    normal_accom_i = p.an;
    tangent_accom_i = p.at;
    wall_speed_ratio_i = p.vw;
    last_panel_i = p.last;
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    r = predict_panel(p);
    pending_q.push_back(known ? typed : r);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // drop start first so that no stale transaction is taken while draining
  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h0000;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic panel_t rand_panel(logic last);
    panel_t p;
    int ax;
    if ($urandom_range(0, 2) == 0) begin
      p.nx = 16'($urandom);
      p.ny = 16'($urandom);
      p.nz = 16'($urandom);
    end else begin
      p.nx = 16'($urandom_range(0, 16383) - 8192);
      p.ny = 16'($urandom_range(0, 16383) - 8192);
      p.nz = 16'($urandom_range(0, 16383) - 8192);
      ax = $urandom_range(0, 2);
      if (ax == 0) p.nx = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      if (ax == 1) p.ny = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      if (ax == 2) p.nz = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    end
    p.area = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
    p.lit = rand_frac();
    p.an = rand_frac();
    p.at = rand_frac();
    p.vw = rand_frac();
    p.last = last;
    return p;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    coeff_res_t e;
    if (rst_ni && valid_o) begin
      if (pending_q.size() == 0) begin
        $error("result with no expectation pending");
        failed = 1;
      end else begin
        e = pending_q.pop_front();
        if (panel_cosine_o !== e.cosine) begin
          $error("panel_cosine exp %0d got %0d", e.cosine, panel_cosine_o);
          failed = 1;
        end
        if (coeff_x_o !== e.cx) begin
          $error("coeff_x exp %0d got %0d", $signed(e.cx), coeff_x_o);
          failed = 1;
        end
        if (coeff_y_o !== e.cy) begin
          $error("coeff_y exp %0d got %0d", $signed(e.cy), coeff_y_o);
          failed = 1;
        end
        if (coeff_z_o !== e.cz) begin
          $error("coeff_z exp %0d got %0d", $signed(e.cz), coeff_z_o);
          failed = 1;
        end
        if (reference_area_o !== e.refa) begin
          $error("reference_area exp %0d got %0d", e.refa, reference_area_o);
          failed = 1;
        end
        if (done_res_o !== e.done) begin
          $error("done_res exp %0d got %0d", e.done, done_res_o);
          failed = 1;
        end
        if (zero_area_o !== e.zarea) begin
          $error("zero_area exp %0d got %0d", e.zarea, zero_area_o);
          failed = 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  row_t dir_rows[$];

  function automatic row_t mk(logic [15:0] nx, ny, nz, area, lit, an, at, vw,
                              logic last, logic known);
    row_t w;
    w.p = '{nx, ny, nz, area, lit, an, at, vw, last};
    w.known = known;
    w.r = '{16'd0, 32'd0, 32'd0, 32'd0, 32'd0, last, last};
    return w;
  endfunction

  initial begin
    panel_t p;
    int len;
    storch_mode = 1'b0;
    flow_x = 0;
    flow_y = 0;
    flow_z = -32768;
    force_x = 0;
    force_y = 0;
    force_z = 0;
    area_sum = 0;

    // back-facing and edge-on panels with clear sums give all-zero results
    dir_rows.push_back(mk(16'h0, 16'h0, 16'h8000, 16'hFFFF, 16'h8000,
                          16'h0, 16'h0, 16'h0, 1'b1, 1'b1));
    dir_rows.push_back(mk(16'h7FFF, 16'h7FFF, 16'h0, 16'h0100, 16'h8000,
                          16'h0, 16'h0, 16'h0, 1'b0, 1'b1));
    // facing panels with no lit fraction or a tiny normal still report a cosine
    dir_rows.push_back(mk(16'h0, 16'h0, 16'h7FFF, 16'hFFFF, 16'h0000,
                          16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
    dir_rows.push_back(mk(16'h0, 16'h0, 16'h0001, 16'hFFFF, 16'h8000,
                          16'h0, 16'h0, 16'h0, 1'b1, 1'b0));
    // lit panels: full, saturated fractions, oversized normal, zero area
    dir_rows.push_back(mk(16'h0, 16'h0, 16'h7FFF, 16'h0100, 16'h8000,
                          16'h0, 16'h0, 16'h0, 1'b1, 1'b0));
    dir_rows.push_back(mk(16'h0, 16'h0, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    dir_rows.push_back(mk(16'h7FFF, 16'h8000, 16'h5A82, 16'h8000, 16'h4000,
                          16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0));
    dir_rows.push_back(mk(16'h8000, 16'h7FFF, 16'h5A82, 16'h0001, 16'h0001,
                          16'h0001, 16'h0001, 16'h0001, 1'b1, 1'b0));
    dir_rows.push_back(mk(16'h0, 16'h0, 16'h7FFF, 16'h0000, 16'h8000,
                          16'h0, 16'h0, 16'h0, 1'b1, 1'b0));
    for (int k = 0; k < 6; k++)
      dir_rows.push_back(mk(16'h1234, 16'hEDCC, 16'h7FFF, 16'hFFFF, 16'h8000,
                            16'h0, 16'h0, 16'h0, k == 5, 1'b0));

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (dir_rows[k]) send_panel(dir_rows[k].p, dir_rows[k].known, dir_rows[k].r);

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      write_reg(pffc_pkg::CFG_MODEL, {15'($urandom), 1'(ph % 2)});
      case (ph)
        0: begin
          write_reg(pffc_pkg::CFG_FLOW_X, 16'h8000);
          write_reg(pffc_pkg::CFG_FLOW_Y, 16'h8000);
          write_reg(pffc_pkg::CFG_FLOW_Z, 16'h8000);
        end
        1: begin
          write_reg(pffc_pkg::CFG_FLOW_X, 16'h7FFF);
          write_reg(pffc_pkg::CFG_FLOW_Y, 16'h7FFF);
          write_reg(pffc_pkg::CFG_FLOW_Z, 16'h7FFF);
        end
        2: begin
          write_reg(pffc_pkg::CFG_FLOW_X, 16'h0);
          write_reg(pffc_pkg::CFG_FLOW_Y, 16'h0);
          write_reg(pffc_pkg::CFG_FLOW_Z, 16'h0);
        end
        3, 4: begin
          write_reg(pffc_pkg::CFG_FLOW_X, 16'h0);
          write_reg(pffc_pkg::CFG_FLOW_Y, 16'h8000);
          write_reg(pffc_pkg::CFG_FLOW_Z, 16'h0);
        end
        default: begin
          write_reg(pffc_pkg::CFG_FLOW_X, 16'($urandom_range(0, 46340) - 23170));
          write_reg(pffc_pkg::CFG_FLOW_Y, 16'($urandom_range(0, 46340) - 23170));
          write_reg(pffc_pkg::CFG_FLOW_Z, 16'($urandom));
        end
      endcase
      for (int n = 0; n < 55; n += len) begin
        len = $urandom_range(1, 8);
        for (int j = 0; j < len; j++) begin
          p = rand_panel(j == len - 1);
          // occasionally drop or misplace the end marker
          if ($urandom_range(0, 15) == 0) p.last = ~p.last;
          send_panel(p, 1'b0, '{default: '0});
        end
      end
      if (!p.last) begin
        p = rand_panel(1'b1);
        send_panel(p, 1'b0, '{default: '0});
      end
    end

    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
